// ===== rtl/lfupr_pkg.sv =====
// Shared types and constants for the LFU page replacement unit.
// No dependencies.
package lfupr_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_IDS_DEF   = 1024;
    localparam int COUNT_BITS_DEF = 16;

    localparam int PAGE_W  = 10;
    localparam int CFG_W   = 5;
    localparam int TOTAL_W = 32;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

// ===== rtl/lfupr_ctrl.sv =====
// Controller for the LFU page replacement unit: request handshake,
// lookup/update sequencing and the result valid flag. Uses lfupr_pkg.
module lfupr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output lfupr_pkg::cmd_t cmd
);

    lfupr_pkg::state_t state_reg, state_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfupr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        in_ready    = 1'b0;
        // drop the result once taken
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            lfupr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lfupr_pkg::ST_UPDATE;
                end
            end
            lfupr_pkg::ST_UPDATE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lfupr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfupr_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/lfupr_dp.sv =====
// Datapath for the LFU page replacement unit: slot list with counts,
// occupancy, capacity register, running totals and result registers.
// Uses lfupr_pkg.
module lfupr_dp #(
    parameter int MAX_FRAMES = lfupr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_IDS   = lfupr_pkg::PAGE_IDS_DEF,
    parameter int COUNT_BITS = lfupr_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfupr_pkg::cmd_t               cmd,
    input  logic                          cfg_write,
    input  logic [lfupr_pkg::CFG_W-1:0]   cfg_data,
    input  logic [lfupr_pkg::PAGE_W-1:0]  page_id,
    output logic                          was_hit,
    output logic                          evict_valid,
    output logic [lfupr_pkg::PAGE_W-1:0]  evicted_page,
    output logic [lfupr_pkg::TOTAL_W-1:0] hit_total,
    output logic [lfupr_pkg::TOTAL_W-1:0] miss_total
);

    localparam int PAGE_W  = lfupr_pkg::PAGE_W;
    localparam int CFG_W   = lfupr_pkg::CFG_W;
    localparam int TOTAL_W = lfupr_pkg::TOTAL_W;
    localparam int OCC_W   = $clog2(MAX_FRAMES + 1);
    localparam int CAP_W   = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    logic [PAGE_W-1:0]     slot_page_reg  [MAX_FRAMES];
    logic [PAGE_W-1:0]     slot_page_next [MAX_FRAMES];
    logic [COUNT_BITS-1:0] slot_count_reg [MAX_FRAMES];
    logic [COUNT_BITS-1:0] slot_count_next[MAX_FRAMES];
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [CFG_W-1:0]      frames_reg, frames_next;
    logic [TOTAL_W-1:0]    hits_reg, hits_next;
    logic [TOTAL_W-1:0]    misses_reg, misses_next;

    // request captured at accept
    logic [PAGE_W-1:0]     page_reg;
    logic                  inrange_reg;
    logic [MAX_FRAMES-1:0] match_reg;

    logic                  was_hit_reg, was_hit_next;
    logic                  evict_valid_reg, evict_valid_next;
    logic [PAGE_W-1:0]     evicted_page_reg, evicted_page_next;

    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] m_set;
    logic [MAX_FRAMES-1:0] m_prev;
    logic [MAX_FRAMES-1:0] below;
    logic [MAX_FRAMES-1:0] tail;
    logic [MAX_FRAMES-1:0] wpos;
    logic [COUNT_BITS-1:0] cnt_old, cnt_new;
    logic [CAP_W-1:0]      cap;
    logic                  hit, miss, full;
    logic [PAGE_W-1:0]     tail_page;

    // residency lookup against the live slots
    always_comb
    begin
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            match[k] = (OCC_W'(k) < occ_reg) && (slot_page_reg[k] == page_id);
        end
    end

    always_comb
    begin
        cap = CAP_W'(frames_reg);
        if (cap == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (cap > CAP_W'(MAX_FRAMES))
        begin
            cap = CAP_W'(MAX_FRAMES);
        end
    end

    assign hit  = inrange_reg && (|match_reg);
    assign miss = inrange_reg && !(|match_reg);
    assign full = CAP_W'(occ_reg) >= cap;

    always_comb
    begin
        cnt_old   = '0;
        tail_page = '0;
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            cnt_old   = cnt_old | (match_reg[k] ? slot_count_reg[k] : '0);
            tail[k]   = (occ_reg == OCC_W'(k + 1));
            wpos[k]   = full ? tail[k] : (occ_reg == OCC_W'(k));
            tail_page = tail_page | (tail[k] ? slot_page_reg[k] : '0);
        end
        cnt_new = (&cnt_old) ? cnt_old : cnt_old + 1'b1;
        // slots ahead of the hit whose count does not exceed the new count
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            below[k] = |(match_reg >> (k + 1));
            m_set[k] = match_reg[k] || (below[k] && (slot_count_reg[k] <= cnt_new));
        end
        m_prev = m_set << 1;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            slot_page_next[k]  = slot_page_reg[k];
            slot_count_next[k] = slot_count_reg[k];
        end
        occ_next          = occ_reg;
        hits_next         = hits_reg;
        misses_next       = misses_reg;
        was_hit_next      = was_hit_reg;
        evict_valid_next  = evict_valid_reg;
        evicted_page_next = evicted_page_reg;
        frames_next       = cfg_write ? cfg_data : frames_reg;

        if (cmd.commit)
        begin
            was_hit_next      = hit;
            evict_valid_next  = miss && full;
            evicted_page_next = (miss && full) ? tail_page : '0;
            if (hit)
            begin
                if (hits_reg != '1)
                begin
                    hits_next = hits_reg + 1'b1;
                end
                // shift the run of counts not above the new count back by one slot
                for (int k = 1; k < MAX_FRAMES; k++)
                begin
                    if (m_prev[k] && m_set[k])
                    begin
                        slot_page_next[k]  = slot_page_reg[k-1];
                        slot_count_next[k] = slot_count_reg[k-1];
                    end
                end
                for (int k = 0; k < MAX_FRAMES; k++)
                begin
                    if (m_set[k] && !m_prev[k])
                    begin
                        slot_page_next[k]  = page_reg;
                        slot_count_next[k] = cnt_new;
                    end
                end
            end
            else if (miss)
            begin
                if (misses_reg != '1)
                begin
                    misses_next = misses_reg + 1'b1;
                end
                for (int k = 0; k < MAX_FRAMES; k++)
                begin
                    if (wpos[k])
                    begin
                        slot_page_next[k]  = page_reg;
                        slot_count_next[k] = COUNT_BITS'(1);
                    end
                end
                if (!full)
                begin
                    occ_next = occ_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            frames_reg <= lfupr_pkg::FRAMES_RESET;
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else
        begin
            occ_reg    <= occ_next;
            frames_reg <= frames_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            slot_page_reg[k]  <= slot_page_next[k];
            slot_count_reg[k] <= slot_count_next[k];
        end
        was_hit_reg      <= was_hit_next;
        evict_valid_reg  <= evict_valid_next;
        evicted_page_reg <= evicted_page_next;
        if (cmd.capture)
        begin
            page_reg    <= page_id;
            inrange_reg <= int'(page_id) < PAGE_IDS;
            match_reg   <= match;
        end
    end

    assign was_hit      = was_hit_reg;
    assign evict_valid  = evict_valid_reg;
    assign evicted_page = evicted_page_reg;
    assign hit_total    = hits_reg;
    assign miss_total   = misses_reg;

endmodule

// ===== rtl/lfu_page_replacement_unit.sv =====
// LFU page replacement unit, top level.
// Sequencing: the slot lookup runs in the accept cycle and is registered; the
// update and the result register load follow in ST_UPDATE, which waits while
// the result register is not taken. A new request is accepted only once the
// current one has been committed and the controller is back in ST_IDLE.
// Reset: list empty, totals zero, frames_in_use 16; no clearing pass.
// Depends on lfupr_pkg, lfupr_ctrl and lfupr_dp.
module lfu_page_replacement_unit #(
    parameter int MAX_FRAMES = lfupr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_IDS   = lfupr_pkg::PAGE_IDS_DEF,
    parameter int COUNT_BITS = lfupr_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lfupr_pkg::CFG_W-1:0]   frames_in_use,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lfupr_pkg::PAGE_W-1:0]  page_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          was_hit,
    output logic                          evict_valid,
    output logic [lfupr_pkg::PAGE_W-1:0]  evicted_page,
    output logic [lfupr_pkg::TOTAL_W-1:0] hit_total,
    output logic [lfupr_pkg::TOTAL_W-1:0] miss_total
);

    lfupr_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    lfupr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    lfupr_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_IDS   (PAGE_IDS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (frames_in_use),
        .page_id      (page_id),
        .was_hit      (was_hit),
        .evict_valid  (evict_valid),
        .evicted_page (evicted_page),
        .hit_total    (hit_total),
        .miss_total   (miss_total)
    );

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evict_valid |-> !was_hit && (miss_total != '0))
        else $error("eviction reported without a miss");

    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evict_valid |-> evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_hit |-> hit_total != '0)
        else $error("hit reported with zero hit total");

endmodule

// ===== verif/lfupr_checker.sv =====
// Scoreboard for the LFU page replacement unit: tracks the resident list and the
// totals from the accepted requests and checks every result against them.
// Depends on lfupr_pkg.
module lfupr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [lfupr_pkg::CFG_W-1:0]   frames_in_use,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [lfupr_pkg::PAGE_W-1:0]  page_id,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          was_hit,
    input  logic                          evict_valid,
    input  logic [lfupr_pkg::PAGE_W-1:0]  evicted_page,
    input  logic [lfupr_pkg::TOTAL_W-1:0] hit_total,
    input  logic [lfupr_pkg::TOTAL_W-1:0] miss_total,
    output int                            mismatches,
    output int                            outstanding
);

    localparam int LIST_DEPTH = lfupr_pkg::MAX_FRAMES_DEF;
    localparam int PAGE_SPACE = lfupr_pkg::PAGE_IDS_DEF;
    localparam int COUNT_W    = lfupr_pkg::COUNT_BITS_DEF;
    localparam int PW         = lfupr_pkg::PAGE_W;
    localparam int TW         = lfupr_pkg::TOTAL_W;

    typedef struct {
        logic          hit;
        logic          evicted;
        logic [PW-1:0] victim;
        logic [TW-1:0] hits;
        logic [TW-1:0] misses;
    } lookup_outcome_t;

    lookup_outcome_t                 pending_outcomes[$];
    logic [PW-1:0]                   list_page [LIST_DEPTH];
    logic [COUNT_W-1:0]              list_uses [LIST_DEPTH];
    int                              list_len;
    logic                            resident [PAGE_SPACE];
    logic [TW-1:0]                   hit_sum;
    logic [TW-1:0]                   miss_sum;
    logic [lfupr_pkg::CFG_W-1:0]     frames_setting;

    // Apply one page reference to the tracked list and return what the unit
    // should report for it.
    task automatic reference_page(input logic [PW-1:0] pg, output lookup_outcome_t res);
        int                 limit;
        int                 pos;
        int                 dst;
        logic [COUNT_W-1:0] uses;
        res.hit     = 1'b0;
        res.evicted = 1'b0;
        res.victim  = '0;
        limit = (frames_setting == 0) ? 1 :
                (frames_setting > LIST_DEPTH) ? LIST_DEPTH : int'(frames_setting);
        if (resident[pg]) begin
            res.hit = 1'b1;
            if (hit_sum != '1)
                hit_sum = hit_sum + 1'b1;
            pos = 0;
            while (pos < list_len && list_page[pos] != pg)
                pos++;
            if (pos < list_len) begin
                uses = list_uses[pos];
                if (uses != '1)
                    uses = uses + 1'b1;
                // slide ahead of every entry whose count does not exceed the new one
                dst = pos;
                while (dst > 0 && list_uses[dst-1] <= uses) begin
                    list_page[dst] = list_page[dst-1];
                    list_uses[dst] = list_uses[dst-1];
                    dst--;
                end
                list_page[dst] = pg;
                list_uses[dst] = uses;
            end
        end
        else begin
            if (miss_sum != '1)
                miss_sum = miss_sum + 1'b1;
            // full list: drop the back entry only, even if capacity shrank below it
            if (list_len >= limit && list_len > 0) begin
                res.evicted = 1'b1;
                res.victim  = list_page[list_len-1];
                resident[res.victim] = 1'b0;
                list_len--;
            end
            if (list_len < LIST_DEPTH) begin
                list_page[list_len] = pg;
                list_uses[list_len] = COUNT_W'(1);
                list_len++;
                resident[pg] = 1'b1;
            end
        end
        res.hits   = hit_sum;
        res.misses = miss_sum;
    endtask

    task automatic check_field(input string label, input logic [TW-1:0] want,
                               input logic [TW-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        lookup_outcome_t fresh;
        lookup_outcome_t oldest;
        if (!rst_n) begin
            pending_outcomes.delete();
            for (int k = 0; k < LIST_DEPTH; k++) begin
                list_page[k] = '0;
                list_uses[k] = '0;
            end
            for (int k = 0; k < PAGE_SPACE; k++)
                resident[k] = 1'b0;
            list_len       = 0;
            hit_sum        = '0;
            miss_sum       = '0;
            frames_setting = lfupr_pkg::FRAMES_RESET;
            outstanding    = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                frames_setting = frames_in_use;
            // compare before adding this edge's request: its result cannot be out yet
            if (out_valid && out_ready) begin
                if (pending_outcomes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result hit=%0d evict=%0d page=%0d",
                             $time, was_hit, evict_valid, evicted_page);
                end
                else begin
                    oldest = pending_outcomes.pop_front();
                    check_field("was_hit", TW'(oldest.hit), TW'(was_hit));
                    check_field("evict_valid", TW'(oldest.evicted), TW'(evict_valid));
                    check_field("evicted_page", TW'(oldest.victim), TW'(evicted_page));
                    check_field("hit_total", oldest.hits, hit_total);
                    check_field("miss_total", oldest.misses, miss_total);
                end
            end
            if (in_valid && in_ready) begin
                reference_page(page_id, fresh);
                pending_outcomes.push_back(fresh);
            end
            outstanding = pending_outcomes.size();
        end
    end

endmodule

// ===== verif/tb_lfu_page_replacement_unit.sv =====
// Top-level testbench for lfu_page_replacement_unit: clock, reset, request and
// frame-setting stimulus, output backpressure and the final verdict.
// Depends on lfupr_pkg, lfu_page_replacement_unit and lfupr_checker.
module tb_lfu_page_replacement_unit;

    localparam int PW          = lfupr_pkg::PAGE_W;
    localparam int CW          = lfupr_pkg::CFG_W;
    localparam int TW          = lfupr_pkg::TOTAL_W;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [CW-1:0] frames_in_use;
    logic          in_valid;
    logic          in_ready;
    logic [PW-1:0] page_id;
    logic          out_valid;
    logic          out_ready;
    logic          was_hit;
    logic          evict_valid;
    logic [PW-1:0] evicted_page;
    logic [TW-1:0] hit_total;
    logic [TW-1:0] miss_total;

    int mismatches;
    int outstanding;
    int requests_sent;
    int settings_used;
    int cycle_count;
    int phase_no;
    bit steady_drain;

    always #10 clk = ~clk;

    lfu_page_replacement_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .frames_in_use(frames_in_use),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .page_id      (page_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .was_hit      (was_hit),
        .evict_valid  (evict_valid),
        .evicted_page (evicted_page),
        .hit_total    (hit_total),
        .miss_total   (miss_total)
    );

    lfupr_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .frames_in_use(frames_in_use),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .page_id      (page_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .was_hit      (was_hit),
        .evict_valid  (evict_valid),
        .evicted_page (evicted_page),
        .hit_total    (hit_total),
        .miss_total   (miss_total),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Hold a request until taken, then idle for a random gap unless told not to.
    task automatic offer_page(input logic [PW-1:0] pg, input bit no_gaps);
        int r;
        int n;
        in_valid <= 1'b1;
        page_id  <= pg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            n = 0;
        else if (r < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 30);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_frames(input logic [CW-1:0] frames);
        cfg_valid     <= 1'b1;
        frames_in_use <= frames;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Stop offering and wait for every result to come back.
    task automatic wait_drained;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // Output side: random stalls, plus one long hold in two of the phases.
    initial begin
        int r;
        int held_in;
        held_in = -1;
        out_ready <= 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (!steady_drain && (phase_no == 3 || phase_no == 8) && held_in != phase_no) begin
                held_in = phase_no;
                out_ready <= 1'b0;
                repeat (150) @(posedge clk);
            end
            else if (steady_drain) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else if (r < 60) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else if (r < 92) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else begin
                out_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    initial begin
        logic [CW-1:0] frames;
        logic [PW-1:0] pg;
        logic [PW-1:0] last_pg;
        int            cap;
        int            pool_base;
        int            pool_size;
        int            r;
        bit            burst;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        frames_in_use <= '0;
        in_valid      <= 1'b0;
        page_id       <= '0;
        phase_no      = -1;
        steady_drain  = 1'b0;
        last_pg       = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Build a high count on one page in a two-frame list, then give a second
        // page a lower count so a new page must evict the one at the back.
        write_frames(CW'(2));
        steady_drain = 1'b1;
        repeat (20) offer_page(PW'(512), 1'b1);
        repeat (11) offer_page(PW'(513), 1'b1);
        offer_page(PW'(514), 1'b1);
        wait_drained;
        steady_drain = 1'b0;

        // Zero capacity acts as one, below the current occupancy; field extremes.
        write_frames(CW'(0));
        offer_page(PW'(0), 1'b0);
        offer_page(PW'(0), 1'b0);
        offer_page(PW'(1023), 1'b0);
        offer_page(PW'(341), 1'b0);
        offer_page(PW'(682), 1'b0);
        wait_drained;

        // Out-of-range capacity clamps to the full list; equal counts move to the front.
        write_frames(CW'(31));
        offer_page(PW'(0), 1'b0);
        offer_page(PW'(1023), 1'b0);
        offer_page(PW'(1023), 1'b0);
        offer_page(PW'(341), 1'b0);
        offer_page(PW'(341), 1'b0);
        offer_page(PW'(341), 1'b0);
        offer_page(PW'(682), 1'b0);
        offer_page(PW'(7), 1'b0);
        offer_page(PW'(7), 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained;
            case (p)
                0:       frames = CW'(16);
                1:       frames = CW'(1);
                2:       frames = CW'(0);
                3:       frames = CW'(31);
                4:       frames = CW'(3);
                5:       frames = CW'(17);
                6:       frames = CW'(8);
                7:       frames = CW'(2);
                8:       frames = CW'(12);
                9:       frames = CW'(24);
                10:      frames = CW'(5);
                default: frames = CW'($urandom_range(0, 31));
            endcase
            write_frames(frames);
            phase_no = p;
            cap = (frames == 0) ? 1 : (frames > 16) ? 16 : int'(frames);
            // working set a little larger than the list: hits and evictions both
            pool_base = $urandom_range(0, 1023);
            pool_size = cap + $urandom_range(0, 5);
            burst     = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    pg = last_pg;
                else if (r < 85)
                    pg = PW'(pool_base + $urandom_range(0, pool_size - 1));
                else
                    pg = PW'($urandom_range(0, 1023));
                offer_page(pg, burst && k < 40);
                last_pg = pg;
            end
        end

        wait_drained;
        repeat (4) @(posedge clk);
        $display("covered %0d page requests under %0d frame settings, clamped and shrunk",
                 requests_sent, settings_used);
        $display("capacities, reordering on equal counts and two long output stalls");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lfupr_pkg.sv
rtl/lfupr_ctrl.sv
rtl/lfupr_dp.sv
rtl/lfu_page_replacement_unit.sv
verif/lfupr_checker.sv
verif/tb_lfu_page_replacement_unit.sv
